>>> hdl/glls_pkg.sv
`timescale 1ns / 1ps

package glls_pkg;

    localparam int VAL_W     = 64;
    localparam int ID_W      = 32;
    localparam int LAG_W     = 6;
    // magnitude of a 6-bit signed lag never exceeds 32
    localparam int MAG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int ENTRY_W   = VAL_W + ID_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LAG_AMOUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_VALUE = 1'b1;

    localparam logic signed [LAG_W-1:0] LAG_RESET     = 6'sd1;
    localparam logic [VAL_W-1:0]        REPLACE_RESET = '0;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_LAG,
        MODE_LEAD
    } mode_t;

    // item handed from the ring access stage to the result stage
    typedef struct packed {
        logic [VAL_W-1:0]        sample_value;
        logic signed [ID_W-1:0]  group_id;
        logic                    end_of_vector;
        mode_t                   mode;
        logic                    have_src;
        logic                    main_beat;
        logic [MAG_W-1:0]        flush_cnt;
    } issue_t;

endpackage

>>> hdl/glls_ram.sv
`timescale 1ns / 1ps

module glls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the entry written in the same cycle returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/glls_ring_ctrl.sv
`timescale 1ns / 1ps

module glls_ring_ctrl #(
    parameter int MAX_LAG = 16,
    localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              clear,
    input  logic signed [glls_pkg::LAG_W-1:0] lag_amount,
    input  logic [glls_pkg::VAL_W-1:0]        sample_value,
    input  logic signed [glls_pkg::ID_W-1:0]  group_id,
    input  logic                              end_of_vector,
    output logic                              ram_we,
    output logic [AW-1:0]                     ram_waddr,
    output logic [AW-1:0]                     ram_raddr,
    output glls_pkg::issue_t                  issue
);

    import glls_pkg::*;

    localparam int SW = $clog2(MAX_LAG + 1);

    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    wp_next;
    logic [SW-1:0]    seen_reg;
    logic [SW-1:0]    seen_next;
    logic [MAG_W-1:0] lag_bits;
    logic [MAG_W-1:0] abs_lag;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] seen_ext;
    logic [MAG_W-1:0] seen_inc;
    logic [MAG_W-1:0] left;
    logic [MAG_W:0]   back_sum;
    logic [MAG_W:0]   back_addr;
    mode_t            mode;
    logic             have;

    always_comb
    begin
        lag_bits = MAG_W'(unsigned'(lag_amount));
        abs_lag  = lag_amount[LAG_W-1] ? (~lag_bits + 1'b1) : lag_bits;
        mag      = (abs_lag > MAG_W'(MAX_LAG)) ? MAG_W'(MAX_LAG) : abs_lag;

        if (lag_amount == '0)
        begin
            mode = MODE_PASS;
        end
        else if (lag_amount[LAG_W-1])
        begin
            mode = MODE_LEAD;
        end
        else
        begin
            mode = MODE_LAG;
        end

        seen_ext = MAG_W'(seen_reg);
        have     = (seen_ext >= mag);
        seen_inc = (seen_ext < MAG_W'(MAX_LAG)) ? seen_ext + 1'b1 : seen_ext;
        left     = (seen_inc < mag) ? seen_inc : mag;

        // slot mag entries behind the write pointer, modulo ring depth
        back_sum  = (MAG_W+1)'(wp_reg) + (MAG_W+1)'(MAX_LAG) - (MAG_W+1)'(mag);
        back_addr = (back_sum >= (MAG_W+1)'(MAX_LAG))
                    ? back_sum - (MAG_W+1)'(MAX_LAG) : back_sum;
        ram_raddr = AW'(back_addr);
    end

    assign ram_we    = accept;
    assign ram_waddr = wp_reg;

    always_comb
    begin
        issue.sample_value  = sample_value;
        issue.group_id      = group_id;
        issue.end_of_vector = end_of_vector;
        issue.mode          = mode;
        issue.have_src      = have;
        issue.main_beat     = (mode != MODE_LEAD) || have;
        issue.flush_cnt     = ((mode == MODE_LEAD) && end_of_vector) ? left : '0;
    end

    always_comb
    begin
        wp_next   = wp_reg;
        seen_next = seen_reg;
        if (clear)
        begin
            wp_next   = '0;
            seen_next = '0;
        end
        else if (accept)
        begin
            if (end_of_vector)
            begin
                wp_next   = '0;
                seen_next = '0;
            end
            else
            begin
                wp_next   = (wp_reg == AW'(MAX_LAG - 1)) ? '0 : wp_reg + 1'b1;
                seen_next = SW'(seen_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
        end
    end

endmodule

>>> hdl/glls_emit.sv
`timescale 1ns / 1ps

module glls_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  glls_pkg::issue_t                 issue,
    input  logic [glls_pkg::VAL_W-1:0]       ram_value,
    input  logic [glls_pkg::ID_W-1:0]        ram_id,
    input  logic [glls_pkg::VAL_W-1:0]       replace_value,
    input  logic                             out_stall,
    output logic                             busy,
    output logic                             out_valid,
    output logic [glls_pkg::VAL_W-1:0]       shifted_value,
    output logic                             was_replaced,
    output logic                             last_output
);

    import glls_pkg::*;

    issue_t           s1_reg;
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic             s1_main_reg;
    logic             s1_main_next;
    logic [MAG_W-1:0] s1_flush_reg;
    logic [MAG_W-1:0] s1_flush_next;

    logic             out_valid_reg;
    logic [VAL_W-1:0] value_reg;
    logic             replaced_reg;
    logic             last_reg;

    logic             pending;
    logic             out_load;
    logic             emit_now;
    logic             last_beat;
    logic             s1_done;
    logic             match;
    logic [VAL_W-1:0] beat_value;
    logic             beat_replaced;
    logic             beat_last;

    always_comb
    begin
        pending   = s1_main_reg || (s1_flush_reg != '0);
        out_load  = !out_valid_reg || !out_stall;
        emit_now  = s1_valid_reg && pending && out_load;
        last_beat = s1_main_reg ? (s1_flush_reg == '0) : (s1_flush_reg == MAG_W'(1));
        s1_done   = s1_valid_reg && (!pending || (out_load && last_beat));
        busy      = s1_valid_reg && !s1_done;
    end

    always_comb
    begin
        match         = (ram_id == unsigned'(s1_reg.group_id));
        beat_value    = replace_value;
        beat_replaced = 1'b1;
        beat_last     = 1'b0;
        if (s1_main_reg)
        begin
            case (s1_reg.mode)
                MODE_PASS:
                begin
                    beat_value    = s1_reg.sample_value;
                    beat_replaced = 1'b0;
                    beat_last     = s1_reg.end_of_vector;
                end
                MODE_LAG:
                begin
                    if (s1_reg.have_src && match)
                    begin
                        beat_value    = ram_value;
                        beat_replaced = 1'b0;
                    end
                    beat_last = s1_reg.end_of_vector;
                end
                MODE_LEAD:
                begin
                    if (match)
                    begin
                        beat_value    = s1_reg.sample_value;
                        beat_replaced = 1'b0;
                    end
                end
                default:
                begin
                    beat_value    = s1_reg.sample_value;
                    beat_replaced = 1'b0;
                    beat_last     = s1_reg.end_of_vector;
                end
            endcase
        end
        else
        begin
            // flush beat: replacement, last one closes the vector
            beat_last = (s1_flush_reg == MAG_W'(1));
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_main_next  = s1_main_reg;
        s1_flush_next = s1_flush_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_main_next  = issue.main_beat;
            s1_flush_next = issue.flush_cnt;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
            s1_main_next  = 1'b0;
            s1_flush_next = '0;
        end
        else if (emit_now)
        begin
            if (s1_main_reg)
            begin
                s1_main_next = 1'b0;
            end
            else
            begin
                s1_flush_next = s1_flush_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_main_reg   <= 1'b0;
            s1_flush_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_main_reg  <= s1_main_next;
            s1_flush_reg <= s1_flush_next;
            if (out_load)
            begin
                out_valid_reg <= emit_now;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= issue;
        end
        if (out_load)
        begin
            value_reg    <= beat_value;
            replaced_reg <= beat_replaced;
            last_reg     <= beat_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign shifted_value = value_reg;
    assign was_replaced  = replaced_reg;
    assign last_output   = last_reg;

endmodule

>>> hdl/grouped_lag_lead_shift.sv
`timescale 1ns / 1ps
// Path: an accepted input beat is registered in the result stage along with its ring read,
// and its result then moves into the output register once that register can load.
// Throughput: one input beat per cycle; a final element under a lead holds in_stall until
// its flushed replacements (up to the lead clamped to MAX_LAG) have moved into the
// output register, one per cycle; a stalled output stalls the input once a beat waits.
// Reset: asynchronous, clears pointers, counts, pipeline valids and configuration
// (lag 1, replacement 0); ring contents stay undefined and need no clearing pass.

module grouped_lag_lead_shift #(
    parameter int MAX_LAG = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [glls_pkg::VAL_W-1:0]           sample_value,
    input  logic signed [glls_pkg::ID_W-1:0]     group_id,
    input  logic                                 end_of_vector,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [glls_pkg::VAL_W-1:0]           shifted_value,
    output logic                                 was_replaced,
    output logic                                 last_output,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [glls_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [glls_pkg::VAL_W-1:0]           cfg_data
);

    import glls_pkg::*;

    localparam int AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

    logic signed [LAG_W-1:0] lag_reg;
    logic [VAL_W-1:0]        replace_reg;
    logic                    cfg_write;
    logic                    lag_write;
    logic                    accept;
    logic                    busy;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;
    issue_t                  issue;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign lag_write = cfg_write && (cfg_index == CFG_LAG_AMOUNT);
    assign in_stall  = busy;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg     <= LAG_RESET;
            replace_reg <= REPLACE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_LAG_AMOUNT:    lag_reg     <= signed'(cfg_data[LAG_W-1:0]);
                CFG_REPLACE_VALUE: replace_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    glls_ring_ctrl #(
        .MAX_LAG (MAX_LAG)
    ) u_ring_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .clear         (lag_write),
        .lag_amount    (lag_reg),
        .sample_value  (sample_value),
        .group_id      (group_id),
        .end_of_vector (end_of_vector),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_raddr     (ram_raddr),
        .issue         (issue)
    );

    glls_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LAG)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({sample_value, unsigned'(group_id)}),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    glls_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .issue         (issue),
        .ram_value     (ram_rdata[ENTRY_W-1:ID_W]),
        .ram_id        (ram_rdata[ID_W-1:0]),
        .replace_value (replace_reg),
        .out_stall     (out_stall),
        .busy          (busy),
        .out_valid     (out_valid),
        .shifted_value (shifted_value),
        .was_replaced  (was_replaced),
        .last_output   (last_output)
    );

endmodule

>>> hdl/glls_checker.sv
`timescale 1ns / 1ps

module glls_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [glls_pkg::VAL_W-1:0]     shifted_value,
    input logic                           was_replaced,
    input logic                           last_output
);

    import glls_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(shifted_value)
            && $stable(was_replaced) && $stable(last_output))
        else $error("stalled result beat changed");

    // while the input is stalled and the output slot is empty, a pending beat is loaded into that slot
    a_stall_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_valid |=> out_valid)
        else $error("input stalled with no result advancing");

    // nothing stalls or shows a result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid && !in_stall)
        else $error("activity right after reset");

    // stall rises only right after an input beat was offered
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !$past(in_stall) |-> $past(in_valid))
        else $error("stall raised without an accepted beat");

endmodule

bind grouped_lag_lead_shift glls_checker u_checker (.*);
